// ----- hw/rtl/etu_pkg.sv -----
package etu_pkg;

    localparam int VALUE_BITS_DEF = 40;

    typedef enum logic [1:0] {
        DIV_REM_BY_D   = 2'd0,
        DIV_PHI_BY_D   = 2'd1,
        DIV_QUOT_BY_D  = 2'd2,
        DIV_PHI_BY_REM = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     rem_take_quot;
        logic     phi_sub_quot;
        logic     d_advance;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic div_zero;
        logic sq_gt_rem;
        logic rem_gt_one;
    } t_dp_stat;

endpackage

// ----- hw/rtl/euler_totient_unit.sv -----
// Euler totient unit. An item on the input channel (i_in_valid, o_in_ready,
// i_n) carries one unsigned integer n, and for each one the output channel
// (o_out_valid, i_out_ready, o_totient) returns one item holding phi(n).
// An input of one gives one, and an input of zero gives zero.
// The number is factored by trial division with candidates 2, 3, 5, 7, ...
// while the candidate squared does not exceed the remaining cofactor.
// All divisions share one restoring divider that retires one quotient bit
// per cycle. Each candidate tried costs one division, plus one for each
// prime factor counted with multiplicity and one more for each distinct
// one. One item is worked on at a time.
// The result sits in an output register, so the next item is accepted while
// a finished result still waits; a stalled receiver holds the result and
// only blocks the unit once the next result is ready to be stored.
// Reset is synchronous and active low; it returns the controller to idle
// and drops o_out_valid. No data is kept from one item to the next.
module euler_totient_unit
    import etu_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_BITS-1:0] i_n,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_BITS-1:0] o_totient
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    etu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    etu_datapath #(
        .VALUE_BITS(VALUE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_n      (i_n),
        .o_totient(o_totient)
    );

endmodule

// ----- hw/rtl/etu_divider.sv -----
module etu_divider
    import etu_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [VALUE_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [VALUE_BITS-1:0] o_remainder
);

    localparam int CW = $clog2(VALUE_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] r_quo;
    logic [VALUE_BITS-1:0] r_part;
    logic [VALUE_BITS-1:0] r_div;

    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS+1:0] diff;
    logic                  fits;

    assign shifted = {r_part, r_quo[VALUE_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};
    assign fits    = ~diff[VALUE_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_part <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], fits};
            if (fits) begin
                r_part <= diff[VALUE_BITS-1:0];
            end else begin
                r_part <= shifted[VALUE_BITS-1:0];
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_part;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a running division");

endmodule

// ----- hw/rtl/etu_datapath.sv -----
module etu_datapath
    import etu_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [VALUE_BITS-1:0] i_n,
    output logic [VALUE_BITS-1:0] o_totient
);

    localparam int DW  = (VALUE_BITS + 1) / 2 + 2;
    localparam int SQW = 2 * DW;

    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_phi;
    logic [DW-1:0]         r_d;
    logic [SQW-1:0]        r_sq;
    logic [VALUE_BITS-1:0] r_out;

    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_divisor;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [VALUE_BITS-1:0] div_part;

    always_comb begin
        div_dividend = r_rem;
        div_divisor  = VALUE_BITS'(r_d);
        case (i_cmd.div_sel)
            DIV_REM_BY_D:   div_dividend = r_rem;
            DIV_PHI_BY_D:   div_dividend = r_phi;
            DIV_QUOT_BY_D:  div_dividend = div_quot;
            DIV_PHI_BY_REM: begin
                div_dividend = r_phi;
                div_divisor  = r_rem;
            end
            default:        div_dividend = r_rem;
        endcase
    end

    etu_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot),
        .o_remainder(div_part)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_n;
            r_phi <= i_n;
            r_d   <= DW'(2);
            r_sq  <= SQW'(4);
        end else begin
            if (i_cmd.rem_take_quot) begin
                r_rem <= div_quot;
            end
            if (i_cmd.phi_sub_quot) begin
                r_phi <= r_phi - div_quot;
            end
            if (i_cmd.d_advance) begin
                if (r_d == DW'(2)) begin
                    r_d  <= DW'(3);
                    r_sq <= SQW'(9);
                end else begin
                    r_d  <= r_d + DW'(2);
                    r_sq <= r_sq + SQW'({r_d, 2'b00}) + SQW'(4);
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_phi;
        end
    end

    assign o_stat.div_done   = div_done;
    assign o_stat.div_zero   = (div_part == '0);
    assign o_stat.sq_gt_rem  = (r_sq > SQW'(r_rem));
    assign o_stat.rem_gt_one = (r_rem > VALUE_BITS'(1));
    assign o_totient         = r_out;

endmodule

// ----- hw/rtl/etu_ctrl.sv -----
module etu_ctrl
    import etu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_TEST    = 8'b0000_0100,
        S_PHI     = 8'b0000_1000,
        S_STRIP   = 8'b0001_0000,
        S_LAST    = 8'b0010_0000,
        S_LASTDIV = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.div_sel = DIV_REM_BY_D;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.sq_gt_rem) begin
                    n_state = S_LAST;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_REM_BY_D;
                    n_state       = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.div_done) begin
                    if (i_stat.div_zero) begin
                        cmd.rem_take_quot = 1'b1;
                        cmd.div_start     = 1'b1;
                        cmd.div_sel       = DIV_PHI_BY_D;
                        n_state           = S_PHI;
                    end else begin
                        cmd.d_advance = 1'b1;
                        n_state       = S_CHECK;
                    end
                end
            end
            S_PHI: begin
                if (i_stat.div_done) begin
                    cmd.phi_sub_quot = 1'b1;
                    cmd.div_start    = 1'b1;
                    cmd.div_sel      = DIV_REM_BY_D;
                    n_state          = S_STRIP;
                end
            end
            S_STRIP: begin
                if (i_stat.div_done) begin
                    if (i_stat.div_zero) begin
                        cmd.rem_take_quot = 1'b1;
                        cmd.div_start     = 1'b1;
                        cmd.div_sel       = DIV_QUOT_BY_D;
                    end else begin
                        cmd.d_advance = 1'b1;
                        n_state       = S_CHECK;
                    end
                end
            end
            S_LAST: begin
                if (i_stat.rem_gt_one) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_PHI_BY_REM;
                    n_state       = S_LASTDIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LASTDIV: begin
                cmd.div_sel = DIV_PHI_BY_REM;
                if (i_stat.div_done) begin
                    cmd.phi_sub_quot = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_TEST || r_state == S_PHI
                             || r_state == S_STRIP || r_state == S_LASTDIV))
        else $error("division finished outside a wait state");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> r_out_valid && r_state == S_IDLE)
        else $error("result load did not present an item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !r_out_valid || i_out_ready)
        else $error("pending result overwritten");

endmodule

// ----- test/euler_totient_unit_tb.sv -----
module euler_totient_unit_tb;
    import etu_pkg::*;

    localparam int W = VALUE_BITS_DEF;
    localparam int unsigned RAND_ITEMS = 80;
    localparam int unsigned PAUSE_AT = 20;
    localparam int unsigned HOLD_AT = 40;
    localparam int unsigned HOLD_CYCLES = 3000;
    localparam int unsigned QUIET_LO = 60;
    localparam int unsigned QUIET_HI = 85;
    localparam int unsigned DRAIN_CYCLES = 4 * (W + 3);

    typedef struct {
        logic [W-1:0] n;
        logic [W-1:0] phi;
    } t_totient_case;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [W-1:0] n_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [W-1:0] totient;

    t_totient_case case_q[$];
    t_totient_case totient_q[$];
    t_totient_case offered;
    int unsigned total_items = 0;
    int unsigned sent_cnt = 0;
    int unsigned got_cnt = 0;
    int unsigned errors = 0;
    int unsigned stall_left = 0;
    bit stall_done = 1'b0;
    longint unsigned work_sum = 0;
    longint unsigned cycle_limit = 64'hFFFF_FFFF;
    longint unsigned cycle_cnt = 0;

    euler_totient_unit #(.VALUE_BITS(W)) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_n        (n_value),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_totient  (totient)
    );

    function automatic logic [W-1:0] totient_of(input logic [W-1:0] n,
                                                output longint unsigned work);
        logic [63:0] rem;
        logic [63:0] phi;
        logic [63:0] d;
        longint unsigned steps;
        rem = n;
        phi = n;
        d = 2;
        steps = 0;
        work = 4 * (W + 3);
        if (n == '0) begin
            return '0;
        end
        while (d * d <= rem) begin
            steps++;
            if (rem % d == 0) begin
                phi = phi / d * (d - 1);
                while (rem % d == 0) begin
                    rem = rem / d;
                    steps++;
                end
            end
            d = (d == 2) ? 64'd3 : d + 64'd2;
        end
        if (rem > 1) begin
            phi = phi / rem * (rem - 1);
        end
        work = (steps + 4) * 2 * (W + 3);
        return phi[W-1:0];
    endfunction

    function automatic void add_case(input logic [63:0] n);
        t_totient_case tc;
        longint unsigned work;
        tc.n = n[W-1:0];
        tc.phi = totient_of(tc.n, work);
        case_q = {case_q, tc};
        work_sum += work;
        total_items++;
    endfunction

    function automatic logic [63:0] smooth_number(input int unsigned fmax);
        logic [63:0] n;
        logic [63:0] f;
        n = 1;
        for (int i = 0; i < 14; i++) begin
            f = $urandom_range(fmax, 2);
            if (n * f < (64'd1 << W)) begin
                n = n * f;
            end
        end
        return n;
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        logic [63:0] directed[$];
        int unsigned kind;
        bit leftover;
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd6, 64'd9, 64'd12, 64'd49,
                     64'd97 * 64'd97, 64'd1021, 64'd1021 * 64'd1021, 64'd991 * 64'd997,
                     64'd65521, (64'd1 << W) - 1, 64'd1 << (W - 1),
                     64'd847288609443, 64'd200560490130, 64'd1 << 20,
                     64'd65535 << (W - 16)};
        leftover = 1'b0;
        foreach (directed[i]) begin
            add_case(directed[i]);
        end
        for (int i = 0; i < RAND_ITEMS; i++) begin
            kind = $urandom_range(9, 0);
            if (kind < 4) begin
                add_case($urandom_range(65535, 1));
            end else if (kind < 8) begin
                add_case(smooth_number(255));
            end else if (kind == 8) begin
                add_case(smooth_number(1023));
            end else begin
                add_case(64'($urandom_range(65535, 0)) << $urandom_range(W - 16, 0));
            end
        end
        cycle_limit = 4 * (work_sum + 200 * total_items + HOLD_CYCLES) + 100000;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (got_cnt != total_items) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (totient_q.size() != 0) begin
            $display("%0t: %0d expected totients never arrived", $time, totient_q.size());
            leftover = 1'b1;
        end
        if (errors == 0 && !leftover) begin
            $display("euler_totient_unit_tb: PASS");
        end else begin
            $display("euler_totient_unit_tb: FAIL");
        end
        $finish;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > cycle_limit) begin
            $display("%0t: run exceeded %0d cycles", $time, cycle_limit);
            $display("euler_totient_unit_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin : offer_proc
        int unsigned next_idx;
        logic offering;
        if (!rst_n) begin
            in_valid <= 1'b0;
            n_value <= '0;
            sent_cnt <= 0;
        end else begin
            next_idx = sent_cnt;
            offering = in_valid;
            if (in_valid && in_ready) begin
                totient_q = {totient_q, offered};
                next_idx = sent_cnt + 1;
                offering = 1'b0;
            end
            sent_cnt <= next_idx;
            if (!offering && case_q.size() != 0
                    && !(next_idx == PAUSE_AT && got_cnt != next_idx)
                    && ((next_idx >= QUIET_LO && next_idx < QUIET_HI)
                        || $urandom_range(99, 0) >= 30)) begin
                offered = case_q.pop_front();
                n_value <= offered.n;
                offering = 1'b1;
            end
            in_valid <= offering;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end else if (!stall_done && got_cnt == HOLD_AT) begin
            stall_left <= HOLD_CYCLES;
            stall_done <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk) begin : collect_proc
        t_totient_case want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            got_cnt <= 0;
        end else begin
            if (out_valid && out_ready) begin
                got_cnt <= got_cnt + 1;
                if (totient_q.size() == 0) begin
                    $display("%0t: unexpected item: expected none, actual %0d",
                             $time, totient);
                    errors <= errors + 1;
                end else begin
                    want = totient_q.pop_front();
                    if (totient !== want.phi) begin
                        $display("%0t: totient of %0d: expected %0d, actual %0d",
                                 $time, want.n, want.phi, totient);
                        errors <= errors + 1;
                    end
                end
            end
            if (stall_left != 0) begin
                out_ready <= 1'b0;
            end else if (got_cnt >= QUIET_LO && got_cnt < QUIET_HI) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99, 0) >= 30);
            end
        end
    end

endmodule

// ----- files.f -----
hw/rtl/etu_pkg.sv
hw/rtl/etu_divider.sv
hw/rtl/etu_datapath.sv
hw/rtl/etu_ctrl.sv
hw/rtl/euler_totient_unit.sv
test/euler_totient_unit_tb.sv
